@@ rtl/rltf_pkg.sv @@
`timescale 1ns / 1ps

package rltf_pkg;

  // Store sizing: the line store is one byte shallower than BUF_DEPTH.
  localparam int BUF_DEPTH = 64;
  localparam int MAX_TERM  = 4;
  localparam int CAPACITY  = BUF_DEPTH - 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ADDR_W    = $clog2(CAPACITY);

  // Terminator length is at most four bytes, or MAX_TERM if that is smaller.
  localparam int TERM_LIM  = (MAX_TERM < 4) ? MAX_TERM : 4;
  localparam int TLEN_W    = 3;
  localparam int TAIL_W    = 32;

  // Request kinds on the input channel.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_TERM_LEN   = 1'b0;
  localparam logic REG_TERM_BYTES = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [TLEN_W-1:0] TERM_LEN_RST   = 3'd2;
  localparam logic [TAIL_W-1:0] TERM_BYTES_RST = 32'd3338;

endpackage

@@ rtl/rltf_ram.sv @@
`timescale 1ns / 1ps

module rltf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rx_line_terminator_framer.sv @@
`timescale 1ns / 1ps

// Line framer for a received byte stream. Each request carries either a byte
// (tuser 0) or a flush (tuser 1). Bytes are kept in a line store; once the most
// recent bytes equal the configured terminator, the line without its
// terminator is sent as a run of bytes with tlast on the final one, or as a
// single result flagged empty when no bytes precede the terminator. A store
// that fills to BUF_DEPTH-1 bytes without a terminator gives one result flagged
// overflow and is discarded. Zero bytes are ignored. A request is taken
// while the block is idle and its output register is free or being emptied.
// A matched line is then sent one byte at a time, each byte through a read
// state and then a load state on the single read port of the line store,
// the load waiting on any output stall, and no request is taken meanwhile. The
// store needs no clearing pass after reset; the block is ready at once.
module rx_line_terminator_framer (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel. tdata: rx_byte[7:0]. tuser: kind[0].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  input  logic                             in_tuser,
  // Result channel. tdata: line_byte[7:0]. tuser: empty_line[0], overflow[1].
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,
  output logic                             out_tlast,
  output logic [1:0]                       out_tuser,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  import rltf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [TLEN_W-1:0] term_len_r;
  logic [TAIL_W-1:0] term_bytes_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  emit_len_r, emit_len_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              cfg_wr;
  logic              in_acc;
  logic              out_free;
  logic [TLEN_W-1:0] eff_len;
  logic [CNT_W-1:0]  base_fill;
  logic [CNT_W-1:0]  new_fill;
  logic [TAIL_W-1:0] new_tail;
  logic [CNT_W-1:0]  line_len;
  logic [3:0]        lane_ok;
  logic              match;
  logic              emit_last;

  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  // Configuration registers; pready is always high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_len_r   <= TERM_LEN_RST;
      term_bytes_r <= TERM_BYTES_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_TERM_LEN:   term_len_r   <= cfg_pwdata[TLEN_W-1:0];
        REG_TERM_BYTES: term_bytes_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_TERM_LEN:   cfg_prdata = {{(32 - TLEN_W){1'b0}}, term_len_r};
      REG_TERM_BYTES: cfg_prdata = term_bytes_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // Handshakes.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Effective terminator length after the zero and saturation rules.
  always_comb begin
    eff_len = term_len_r;
    if (eff_len == '0) begin
      eff_len = TLEN_W'(1);
    end
    if (eff_len > TLEN_W'(TERM_LIM)) begin
      eff_len = TLEN_W'(TERM_LIM);
    end
  end

  // Append the byte and compare the tail with the terminator lane by lane.
  always_comb begin
    base_fill = (fill_r >= CNT_W'(CAPACITY)) ? '0 : fill_r;
    new_fill  = base_fill + CNT_W'(1);
    new_tail  = (fill_r >= CNT_W'(CAPACITY)) ? {TAIL_W{1'b0}} | TAIL_W'(in_tdata)
                                              : {tail_r[TAIL_W-9:0], in_tdata};
    for (int j = 0; j < 4; j++) begin
      lane_ok[j] = (TLEN_W'(j) >= eff_len) ||
                   (new_tail[8*j +: 8] == term_bytes_r[8*j +: 8]);
    end
    match    = (new_fill >= CNT_W'(eff_len)) && (&lane_ok);
    line_len = new_fill - CNT_W'(eff_len);
  end

  assign ram_we    = in_acc && (in_tuser == KIND_BYTE) && (in_tdata != 8'd0);
  assign ram_re    = (state_r == S_READ);
  assign emit_last = (idx_r + CNT_W'(1)) == emit_len_r;

  // Sequencer: take requests when idle, then walk the stored line.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    tail_nxt      = tail_r;
    emit_len_nxt  = emit_len_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == KIND_FLUSH)) begin
          fill_nxt = '0;
          tail_nxt = '0;
        end else if (ram_we) begin
          if (match) begin
            fill_nxt = '0;
            tail_nxt = '0;
            if (line_len == '0) begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = 8'd0;
              out_last_nxt  = 1'b1;
              out_empty_nxt = 1'b1;
              out_ovf_nxt   = 1'b0;
            end else begin
              emit_len_nxt = line_len;
              idx_nxt      = '0;
              state_nxt    = S_READ;
            end
          end else if (new_fill >= CNT_W'(CAPACITY)) begin
            fill_nxt      = '0;
            tail_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = 8'd0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b0;
            out_ovf_nxt   = 1'b1;
          end else begin
            fill_nxt = new_fill;
            tail_nxt = new_tail;
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ram_rdata;
          out_last_nxt  = emit_last;
          out_empty_nxt = 1'b0;
          out_ovf_nxt   = 1'b0;
          idx_nxt       = idx_r + CNT_W'(1);
          state_nxt     = emit_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    emit_len_r  <= emit_len_nxt;
    idx_r       <= idx_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Line store.
  rltf_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (base_fill[ADDR_W-1:0]),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

  // The fill count never rests at capacity.
  a_fill_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CNT_W'(CAPACITY))
    else $error("line store fill count reached capacity");

  // The store is never written while a line is being read out.
  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ram_we)
    else $error("line store written during emission");

  // Loading the final byte of a line returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && out_free && emit_last) |=> (state_r == S_IDLE))
    else $error("emission did not end after final byte");

  // Flagged results are single, marked last and carry no byte.
  a_flag_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_empty_r || out_ovf_r)) |->
      (out_last_r && out_byte_r == 8'd0 && !(out_empty_r && out_ovf_r)))
    else $error("malformed empty or overflow result");

endmodule
